>>> hdl/evq_pkg.sv
// Package for the event queue subscriber router.
// Holds the sizes, function and status codes, and the memory entry and
// request types shared by the channel interfaces, the controller and the top level.
package evq_pkg;

    localparam int SUB_SLOTS    = 32;
    localparam int QUEUE_SLOTS  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int SOURCE_BITS  = 8;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SUB_IDX_W = 5;

    localparam int SUB_AW    = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
    localparam int SUB_CNT_W = $clog2(SUB_SLOTS + 1);
    localparam int Q_AW      = $clog2(QUEUE_SLOTS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SUBSCRIBE = 2'd0,
        FUNC_PUBLISH   = 2'd1,
        FUNC_DISPATCH  = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_TABLE_FULL  = 3'd1,
        STAT_QUEUE_FULL  = 3'd2,
        STAT_QUEUE_EMPTY = 3'd3,
        STAT_NO_MATCH    = 3'd4
    } status_t;

    typedef struct packed {
        logic [SOURCE_BITS-1:0] src;
        logic                   handler;
    } sub_entry_t;

    typedef struct packed {
        logic [SOURCE_BITS-1:0]  src;
        logic [PAYLOAD_BITS-1:0] payload;
    } q_entry_t;

    typedef struct packed {
        logic              we;
        logic [SUB_AW-1:0] waddr;
        sub_entry_t        wdata;
        logic              re;
        logic [SUB_AW-1:0] raddr;
    } sub_req_t;

    typedef struct packed {
        logic            we;
        logic [Q_AW-1:0] waddr;
        q_entry_t        wdata;
        logic            re;
        logic [Q_AW-1:0] raddr;
    } q_req_t;

endpackage

>>> hdl/evq_channels.sv
// Valid/ready channel interfaces for the event queue subscriber router.
// Depends on evq_pkg for the field widths.
interface evq_in_if;
    logic                             valid;
    logic                             ready;
    logic [evq_pkg::FUNC_W-1:0]       func;
    logic [evq_pkg::SOURCE_BITS-1:0]  source_id;
    logic [evq_pkg::PAYLOAD_BITS-1:0] event_data;
    logic                             has_handler;

    modport source (output valid, func, source_id, event_data, has_handler, input ready);
    modport sink   (input valid, func, source_id, event_data, has_handler, output ready);
endinterface

interface evq_out_if;
    logic                             valid;
    logic                             ready;
    logic [evq_pkg::STATUS_W-1:0]     status;
    logic [evq_pkg::SUB_IDX_W-1:0]    subscriber_index;
    logic [evq_pkg::SOURCE_BITS-1:0]  event_source;
    logic [evq_pkg::PAYLOAD_BITS-1:0] event_payload;
    logic                             last;

    modport source (output valid, status, subscriber_index, event_source, event_payload, last,
                    input ready);
    modport sink   (input valid, status, subscriber_index, event_source, event_payload, last,
                    output ready);
endinterface

>>> hdl/evq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds its value while no read is enabled. No dependencies.
module evq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/evq_ctrl.sv
// Controller of the event router: takes items, updates the table count and
// queue pointers, scans the subscriber memory on dispatch and drives the result register.
// Depends on evq_pkg and the channel interfaces in evq_channels.sv.
module evq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    evq_in_if.sink                in,
    evq_out_if.source             out,
    output evq_pkg::sub_req_t     sub_req,
    input  evq_pkg::sub_entry_t   sub_rdata,
    output evq_pkg::q_req_t       q_req,
    input  evq_pkg::q_entry_t     q_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                                state_reg, state_next;
    logic [evq_pkg::SUB_CNT_W-1:0]         sub_total_reg, sub_total_next;
    logic [evq_pkg::Q_AW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [evq_pkg::Q_AW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [evq_pkg::SOURCE_BITS-1:0]       ev_src_reg, ev_src_next;
    logic [evq_pkg::PAYLOAD_BITS-1:0]      ev_pay_reg, ev_pay_next;
    logic [evq_pkg::SUB_CNT_W-1:0]         issue_idx_reg, issue_idx_next;
    logic                                  chk_valid_reg, chk_valid_next;
    logic [evq_pkg::SUB_AW-1:0]            chk_idx_reg, chk_idx_next;
    logic                                  pend_valid_reg, pend_valid_next;
    logic [evq_pkg::SUB_AW-1:0]            pend_idx_reg, pend_idx_next;
    logic                                  out_valid_reg, out_valid_next;
    evq_pkg::status_t                      out_status_reg, out_status_next;
    logic [evq_pkg::SUB_IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic [evq_pkg::SOURCE_BITS-1:0]       out_src_reg, out_src_next;
    logic [evq_pkg::PAYLOAD_BITS-1:0]      out_pay_reg, out_pay_next;
    logic                                  out_last_reg, out_last_next;

    logic                     out_free;
    logic                     in_fire;
    logic [evq_pkg::Q_AW-1:0] wr_ptr_inc;
    logic [evq_pkg::Q_AW-1:0] rd_ptr_inc;
    logic                     q_empty;
    logic                     q_full;
    logic                     hit;
    logic                     stall;

    assign out_free   = !out_valid_reg || out.ready;
    assign in.ready   = (state_reg == ST_IDLE) && out_free;
    assign in_fire    = in.valid && in.ready;
    assign wr_ptr_inc = (wr_ptr_reg == evq_pkg::Q_AW'(evq_pkg::QUEUE_SLOTS - 1))
                        ? '0 : wr_ptr_reg + evq_pkg::Q_AW'(1);
    assign rd_ptr_inc = (rd_ptr_reg == evq_pkg::Q_AW'(evq_pkg::QUEUE_SLOTS - 1))
                        ? '0 : rd_ptr_reg + evq_pkg::Q_AW'(1);
    assign q_empty    = (rd_ptr_reg == wr_ptr_reg);
    assign q_full     = (wr_ptr_inc == rd_ptr_reg);

    // A table entry hits when it listens to this source or to all sources.
    assign hit   = chk_valid_reg && sub_rdata.handler
                   && ((sub_rdata.src == ev_src_reg) || (sub_rdata.src == '0));
    // A second hit cannot be taken while the earlier one still waits for the result register.
    assign stall = hit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        sub_total_next  = sub_total_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        ev_src_next     = ev_src_reg;
        ev_pay_next     = ev_pay_reg;
        issue_idx_next  = issue_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out.ready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_src_next    = out_src_reg;
        out_pay_next    = out_pay_reg;
        out_last_next   = out_last_reg;
        sub_req         = '0;
        q_req           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_idx_next  = '0;
                    out_src_next  = '0;
                    out_pay_next  = '0;
                    out_last_next = 1'b1;
                    unique case (in.func)
                        evq_pkg::FUNC_SUBSCRIBE:
                        begin
                            out_valid_next = 1'b1;
                            if (sub_total_reg >= evq_pkg::SUB_CNT_W'(evq_pkg::SUB_SLOTS))
                            begin
                                out_status_next = evq_pkg::STAT_TABLE_FULL;
                            end
                            else
                            begin
                                sub_req.we          = 1'b1;
                                sub_req.waddr       = sub_total_reg[evq_pkg::SUB_AW-1:0];
                                sub_req.wdata.src     = in.source_id;
                                sub_req.wdata.handler = in.has_handler;
                                out_status_next     = evq_pkg::STAT_OK;
                                out_idx_next        = evq_pkg::SUB_IDX_W'(sub_total_reg);
                                sub_total_next      = sub_total_reg + evq_pkg::SUB_CNT_W'(1);
                            end
                        end
                        evq_pkg::FUNC_PUBLISH:
                        begin
                            out_valid_next = 1'b1;
                            if (q_full)
                            begin
                                out_status_next = evq_pkg::STAT_QUEUE_FULL;
                            end
                            else
                            begin
                                q_req.we            = 1'b1;
                                q_req.waddr         = wr_ptr_reg;
                                q_req.wdata.src     = in.source_id;
                                q_req.wdata.payload = in.event_data;
                                wr_ptr_next         = wr_ptr_inc;
                                out_status_next     = evq_pkg::STAT_OK;
                            end
                        end
                        evq_pkg::FUNC_DISPATCH:
                        begin
                            if (q_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = evq_pkg::STAT_QUEUE_EMPTY;
                            end
                            else
                            begin
                                q_req.re    = 1'b1;
                                q_req.raddr = rd_ptr_reg;
                                rd_ptr_next = rd_ptr_inc;
                                state_next  = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            // Unused code: the item is taken and leaves no trace.
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                ev_src_next     = q_rdata.src;
                ev_pay_next     = q_rdata.payload;
                issue_idx_next  = '0;
                chk_valid_next  = 1'b0;
                pend_valid_next = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!chk_valid_reg && (issue_idx_reg == sub_total_reg))
                begin
                    state_next = ST_DONE;
                end
                else if (!stall)
                begin
                    if (hit)
                    begin
                        // The held hit is now known not to be the final one.
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = evq_pkg::STAT_OK;
                            out_idx_next    = evq_pkg::SUB_IDX_W'(pend_idx_reg);
                            out_src_next    = ev_src_reg;
                            out_pay_next    = ev_pay_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = chk_idx_reg;
                    end
                    if (issue_idx_reg < sub_total_reg)
                    begin
                        sub_req.re     = 1'b1;
                        sub_req.raddr  = issue_idx_reg[evq_pkg::SUB_AW-1:0];
                        chk_valid_next = 1'b1;
                        chk_idx_next   = issue_idx_reg[evq_pkg::SUB_AW-1:0];
                        issue_idx_next = issue_idx_reg + evq_pkg::SUB_CNT_W'(1);
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_src_next   = ev_src_reg;
                    out_pay_next   = ev_pay_reg;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status_next = evq_pkg::STAT_OK;
                        out_idx_next    = evq_pkg::SUB_IDX_W'(pend_idx_reg);
                    end
                    else
                    begin
                        out_status_next = evq_pkg::STAT_NO_MATCH;
                        out_idx_next    = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sub_total_reg  <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sub_total_reg  <= sub_total_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_src_reg     <= ev_src_next;
        ev_pay_reg     <= ev_pay_next;
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        pend_idx_reg   <= pend_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_src_reg    <= out_src_next;
        out_pay_reg    <= out_pay_next;
        out_last_reg   <= out_last_next;
    end

    assign out.valid            = out_valid_reg;
    assign out.status           = out_status_reg;
    assign out.subscriber_index = out_idx_reg;
    assign out.event_source     = out_src_reg;
    assign out.event_payload    = out_pay_reg;
    assign out.last             = out_last_reg;

`ifndef SYNTHESIS
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sub_total_reg <= evq_pkg::SUB_CNT_W'(evq_pkg::SUB_SLOTS))
        else $error("subscriber count beyond table size");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_req.re |-> (rd_ptr_reg != wr_ptr_reg))
        else $error("queue read while empty");

    a_check_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (evq_pkg::SUB_CNT_W'(chk_idx_reg) < sub_total_reg))
        else $error("scan checks an entry beyond the table");

    a_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sub_req.we |-> (state_reg == ST_IDLE) && !sub_req.re)
        else $error("table written during a scan");
`endif

endmodule

>>> hdl/event_queue_subscriber_router_top.sv
// Top level of the event queue subscriber router: the subscriber table memory,
// the event ring memory and the controller. Depends on evq_pkg, evq_channels,
// evq_ram and evq_ctrl.
//
//   port   direction  fields
//   in     sink       func, source_id, event_data, has_handler
//   out    source     status, subscriber_index, event_source, event_payload, last
//
// Subscribe, publish and dispatch on an empty queue are answered without leaving the idle state.
// A dispatch holds the input after it is taken while the controller does one ring read,
// one table read per subscriber entry through the single read port of the table memory,
// a check of the last entry and the close of the scan, and then gives a final result; with
// an empty table there are no table reads and no check of the last entry.
// Stalls on the result channel hold the scan; a new item is taken only once the result
// register is free, at the earliest in the cycle in which the last result is taken.
// Reset clears the counters and pointers at once; the memories need no clearing.
module event_queue_subscriber_router_top (
    input  logic      clk,
    input  logic      rst_n,
    evq_in_if.sink    in,
    evq_out_if.source out
);

    evq_pkg::sub_req_t   sub_req;
    evq_pkg::sub_entry_t sub_rdata;
    evq_pkg::q_req_t     q_req;
    evq_pkg::q_entry_t   q_rdata;

    logic [$bits(evq_pkg::sub_entry_t)-1:0] sub_wdata_vec;
    logic [$bits(evq_pkg::sub_entry_t)-1:0] sub_rdata_vec;
    logic [$bits(evq_pkg::q_entry_t)-1:0]   q_wdata_vec;
    logic [$bits(evq_pkg::q_entry_t)-1:0]   q_rdata_vec;

    assign sub_wdata_vec = sub_req.wdata;
    assign sub_rdata     = evq_pkg::sub_entry_t'(sub_rdata_vec);
    assign q_wdata_vec   = q_req.wdata;
    assign q_rdata       = evq_pkg::q_entry_t'(q_rdata_vec);

    evq_ram #(
        .WIDTH ($bits(evq_pkg::sub_entry_t)),
        .DEPTH (evq_pkg::SUB_SLOTS),
        .AW    (evq_pkg::SUB_AW)
    ) u_sub_ram (
        .clk   (clk),
        .we    (sub_req.we),
        .waddr (sub_req.waddr),
        .wdata (sub_wdata_vec),
        .re    (sub_req.re),
        .raddr (sub_req.raddr),
        .rdata (sub_rdata_vec)
    );

    evq_ram #(
        .WIDTH ($bits(evq_pkg::q_entry_t)),
        .DEPTH (evq_pkg::QUEUE_SLOTS),
        .AW    (evq_pkg::Q_AW)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_req.we),
        .waddr (q_req.waddr),
        .wdata (q_wdata_vec),
        .re    (q_req.re),
        .raddr (q_req.raddr),
        .rdata (q_rdata_vec)
    );

    evq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .out       (out),
        .sub_req   (sub_req),
        .sub_rdata (sub_rdata),
        .q_req     (q_req),
        .q_rdata   (q_rdata)
    );

endmodule
